/* design/dq_pkg.sv */
// dq_pkg: shared types, codes and ring helper for the double-ended queue
// no dependencies; used by dq_ctrl, dq_datapath and double_ended_queue
`default_nettype none

package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;
    localparam int WORD_W = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [WORD_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // (base + off) modulo DEPTH, for base < DEPTH and off <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/dq_ctrl.sv */
// dq_ctrl: sequencer for accept, execute and result beats
// depends on dq_pkg
`default_nettype none

module dq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output dq_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

`default_nettype wire

/* design/dq_datapath.sv */
// dq_datapath: ring store, head and count registers, result registers
// depends on dq_pkg
`default_nettype none

module dq_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire dq_pkg::t_cmd i_cmd,
    input  wire dq_pkg::t_in  i_in_data,
    output dq_pkg::t_out     o_out_data
);

    logic [dq_pkg::WORD_W-1:0] r_mem [dq_pkg::DEPTH];

    logic [2:0]                r_op;
    logic [dq_pkg::WORD_W-1:0] r_value;
    logic [dq_pkg::ADDR_W-1:0] r_head;
    logic [dq_pkg::ADDR_W-1:0] n_head;
    logic [dq_pkg::CNT_W-1:0]  r_count;
    logic [dq_pkg::CNT_W-1:0]  n_count;
    logic [dq_pkg::WORD_W-1:0] r_rd_data;
    logic                      r_rd_ok;
    logic                      n_rd_ok;
    logic [1:0]                r_status;
    logic [1:0]                n_status;

    logic                      empty;
    logic                      full;
    logic [dq_pkg::ADDR_W-1:0] head_dec;
    logic [dq_pkg::ADDR_W-1:0] back_slot;
    logic [dq_pkg::ADDR_W-1:0] tail_slot;
    logic                      mem_we;
    logic [dq_pkg::ADDR_W-1:0] mem_waddr;
    logic [dq_pkg::ADDR_W-1:0] mem_raddr;

    assign empty     = (r_count == '0);
    assign full      = (r_count >= dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign head_dec  = (r_head == '0) ? dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1)
                                      : r_head - 1'b1;
    assign back_slot = dq_pkg::ring_add(r_head, r_count - 1'b1);
    assign tail_slot = dq_pkg::ring_add(r_head, r_count);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = dq_pkg::ST_OK;
        n_rd_ok   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_raddr = r_head;
        case (r_op)
            dq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    n_head    = head_dec;
                    n_count   = r_count + 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = head_dec;
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    n_count   = r_count + 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = tail_slot;
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                    n_head  = dq_pkg::ring_add(r_head, dq_pkg::CNT_W'(1));
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_rd_ok   = 1'b1;
                    n_count   = r_count - 1'b1;
                    mem_raddr = back_slot;
                end
            end
            dq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            dq_pkg::OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_rd_ok   = 1'b1;
                    mem_raddr = back_slot;
                end
            end
            default: begin
                n_status = dq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[mem_waddr] <= r_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_data.operation;
            r_value <= i_in_data.push_value;
        end
        if (i_cmd.exec) begin
            r_rd_ok  <= n_rd_ok;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_out_data.read_value = r_rd_ok ? r_rd_data : '0;
    assign o_out_data.status     = r_status;
    assign o_out_data.occupancy  = dq_pkg::OCC_W'(r_count);

endmodule

`default_nettype wire

/* design/double_ended_queue.sv */
// double_ended_queue: top level joining the sequencer and the datapath
// depends on dq_pkg, dq_ctrl, dq_datapath
//
//   channel   direction   handshake                 beat
//   in        sink        i_in_valid / o_in_stall   operation, push_value
//   out       source      o_out_valid / i_out_stall read_value, status, occupancy
//
// each item passes through accept, execute and result, and waits in result while the output stalls
// the execute cycle does the store write or the registered store read
// one item is in flight at a time; input stalls until its result beat is taken
// synchronous active-low reset clears head, count and sequencer; store is unset
`default_nettype none

module double_ended_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire dq_pkg::t_in i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output dq_pkg::t_out     o_out_data
);

    dq_pkg::t_cmd cmd;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    dq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

/* test/double_ended_queue_chk.sv */
// double_ended_queue_chk: watches both channels, predicts each result beat and compares it
// depends on dq_pkg for the beat types, operation and status codes
`timescale 1ns / 1ps

module double_ended_queue_chk import dq_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_in_stall,
    input  t_in  i_in_data,
    input  wire  i_out_valid,
    input  wire  i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_hits,
    output int   o_empty_hits
);

    localparam int DUE_DEPTH = 64;

    logic [WORD_W-1:0] ring [DEPTH];
    int unsigned       front_slot;
    int unsigned       held;
    t_out              due_list [DUE_DEPTH];
    int unsigned       due_head;
    int unsigned       due_count;
    t_out              want;
    int                errs;
    int                checked;
    int                fulls;
    int                empties;

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_hits  = 0;
        o_empty_hits = 0;
        errs         = 0;
        checked      = 0;
        fulls        = 0;
        empties      = 0;
        front_slot   = 0;
        held         = 0;
        due_head     = 0;
        due_count    = 0;
    end

    function automatic t_out deque_op(input t_in beat);
        t_out        r;
        int unsigned back_slot;
        r = '0;
        back_slot = (front_slot + held + DEPTH - 1) % DEPTH;
        case (beat.operation)
            OP_PUSH_FRONT: begin
                if (held == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    ring[front_slot] = beat.push_value;
                    held++;
                end
            end
            OP_PUSH_BACK: begin
                if (held == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring[(front_slot + held) % DEPTH] = beat.push_value;
                    held++;
                end
            end
            OP_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ring[front_slot];
                    front_slot = (front_slot + 1) % DEPTH;
                    held--;
                end
            end
            OP_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ring[back_slot];
                    held--;
                end
            end
            OP_PEEK_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ring[front_slot];
                end
            end
            OP_PEEK_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ring[back_slot];
                end
            end
            default: begin
            end
        endcase
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot = 0;
            held = 0;
            due_head = 0;
            due_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_count == 0) begin
                    $error("result beat with none due: read_value %0d status %0d occupancy %0d",
                           i_out_data.read_value, i_out_data.status, i_out_data.occupancy);
                    errs++;
                end else begin
                    want = due_list[due_head];
                    due_head = (due_head + 1) % DUE_DEPTH;
                    due_count--;
                    checked++;
                    if (i_out_data.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, i_out_data.read_value);
                        errs++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                        errs++;
                    end
                    if (i_out_data.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, i_out_data.occupancy);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = deque_op(i_in_data);
                if (want.status == ST_FULL) begin
                    fulls++;
                end
                if (want.status == ST_EMPTY) begin
                    empties++;
                end
                if (due_count == DUE_DEPTH) begin
                    $error("too many result beats outstanding: %0d", due_count);
                    errs++;
                end else begin
                    due_list[(due_head + due_count) % DUE_DEPTH] = want;
                    due_count++;
                end
            end
        end
        o_errors     <= errs;
        o_pending    <= int'(due_count);
        o_checked    <= checked;
        o_full_hits  <= fulls;
        o_empty_hits <= empties;
    end

endmodule

/* test/double_ended_queue_tb.sv */
// double_ended_queue_tb: drives directed and random operation beats into the deque under
// four idle/stall mixes and gives the verdict; depends on dq_pkg, double_ended_queue_chk
`timescale 1ns / 1ps

module double_ended_queue_tb;
    import dq_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 170;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_beat = '0;
    logic in_stall;
    logic out_valid;
    t_out out_beat;

    int errors;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;
    int cycles    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    double_ended_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    double_ended_queue_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_beat),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_hits  (full_hits),
        .o_empty_hits (empty_hits)
    );

    always @(posedge i_clk) begin
        out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("double_ended_queue_tb: FAIL");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(input logic [2:0] op, input logic [WORD_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat.operation  <= op;
        in_beat.push_value <= val;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_read();
        case ($urandom_range(3))
            0: return OP_POP_FRONT;
            1: return OP_POP_BACK;
            2: return OP_PEEK_FRONT;
            default: return OP_PEEK_BACK;
        endcase
    endfunction

    function automatic logic [2:0] pick_op(input t_mix mix);
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            return r[0] ? OP_SPARE_HI : OP_SPARE_LO;
        end
        case (mix)
            MIX_FILL: return (r < 75) ? pick_push() : pick_read();
            MIX_DRAIN: begin
                if (r < 70) begin
                    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                return (r < 85) ? pick_read() : pick_push();
            end
            default: return (r < 40) ? pick_push() : pick_read();
        endcase
    endfunction

    initial begin
        int   phase;
        int   left;
        int   run;
        t_mix mix;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, spare selectors
        send_beat(OP_POP_FRONT, $urandom());
        send_beat(OP_POP_BACK, $urandom());
        send_beat(OP_PEEK_FRONT, $urandom());
        send_beat(OP_PEEK_BACK, $urandom());
        send_beat(OP_SPARE_LO, $urandom());
        send_beat(OP_SPARE_HI, $urandom());
        // single word taken from either end
        send_beat(OP_PUSH_FRONT, 32'h8000_0000);
        send_beat(OP_POP_FRONT, '0);
        send_beat(OP_PUSH_BACK, 32'h7fff_ffff);
        send_beat(OP_POP_BACK, '1);
        // fill to the top from both ends, then push into a full queue
        for (int k = 0; k < DEPTH; k++) begin
            send_beat(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      (k < 4) ? pick_word() : $urandom());
        end
        send_beat(OP_PUSH_FRONT, $urandom());
        send_beat(OP_PUSH_BACK, $urandom());

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default: begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            left = PHASE_ITEMS;
            while (left > 0) begin
                mix = t_mix'($urandom_range(2));
                run = $urandom_range(24, 8);
                for (int k = 0; k < run && left > 0; k++) begin
                    send_beat(pick_op(mix), pick_word());
                    left--;
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d operation beats sent under four idle/stall mixes, %0d results checked",
                 sent, checked);
        $display("pushes refused as full: %0d, pops or peeks refused as empty: %0d",
                 full_hits, empty_hits);
        if (errors == 0) begin
            $display("double_ended_queue_tb: PASS");
        end else begin
            $display("double_ended_queue_tb: FAIL");
        end
        $finish;
    end

endmodule
